// ===== hdl/tca_pkg.sv =====
// ----------------------------------------------------------------------------
// tca_pkg
// shared constants of the three-component gain control block
// ----------------------------------------------------------------------------
package tca_pkg;

    localparam int CFG_W      = 6;
    localparam int GAIN_W     = 32;
    localparam int GAIN_FRAC  = 28;
    localparam int ROOT_SHIFT = 2 * GAIN_FRAC;
    localparam int OUT_SHIFT  = 10;

    localparam logic [CFG_W-1:0] HALF_WINDOW_RESET = 6'd8;

endpackage

// ===== hdl/tca_lane.sv =====
// ----------------------------------------------------------------------------
// tca_lane
// one component lane: squared magnitude and gain scaling with saturation
// ----------------------------------------------------------------------------
module tca_lane
    import tca_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [GAIN_W-1:0]             i_gain,
    output logic [2*SAMPLE_BITS-1:0]      o_square,
    output logic signed [SAMPLE_BITS-1:0] o_scaled
);

    localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;
    localparam logic signed [PROD_W-1:0] SAT_HI =
        PROD_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);

    logic [SAMPLE_BITS-1:0]         mag;
    logic [2*SAMPLE_BITS-1:0]       r_square;
    logic signed [PROD_W-1:0]       r_prod;
    logic signed [PROD_W-1:0]       shifted;

    // the most negative value maps onto its own pattern, read unsigned
    assign mag = i_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_sample) : SAMPLE_BITS'(i_sample);

    always_ff @(posedge i_clk) begin
        r_square <= mag * mag;
        r_prod   <= PROD_W'(i_sample) * $signed({{(SAMPLE_BITS+1){1'b0}}, i_gain});
    end

    // arithmetic shift gives the floor for both signs
    assign shifted = r_prod >>> OUT_SHIFT;

    always_comb begin
        if (shifted > SAT_HI) begin
            o_scaled = SAT_HI[SAMPLE_BITS-1:0];
        end else if (shifted < SAT_LO) begin
            o_scaled = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            o_scaled = shifted[SAMPLE_BITS-1:0];
        end
    end

    assign o_square = r_square;

endmodule

// ===== hdl/tca_rsqrt.sv =====
// ----------------------------------------------------------------------------
// tca_rsqrt
// bit-serial gain search: largest g with g*g*ssq <= 3*count*2^56
// ----------------------------------------------------------------------------
module tca_rsqrt
    import tca_pkg::*;
#(
    parameter int SSQ_W = 54,
    parameter int CNT_W = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SSQ_W-1:0]  i_ssq,
    input  logic [CNT_W-1:0]  i_cnt,
    output logic              o_done,
    output logic [GAIN_W-1:0] o_gain
);

    localparam int ACC_W = SSQ_W + 2 * GAIN_W + 1;
    localparam int BIT_W = $clog2(GAIN_W);

    logic [ACC_W-1:0]  r_p;
    logic [ACC_W-1:0]  r_a;
    logic [ACC_W-1:0]  r_b;
    logic [ACC_W-1:0]  r_lim;
    logic [GAIN_W-1:0] r_gain;
    logic [BIT_W-1:0]  r_bit;
    logic              r_busy;
    logic              r_done;
    logic [ACC_W-1:0]  cand;

    // p = g^2*ssq, a = g*ssq << (b+1), b = ssq << 2b
    assign cand = r_p + r_a + r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_p    <= '0;
                r_a    <= '0;
                r_b    <= ACC_W'(i_ssq) << (2 * (GAIN_W - 1));
                r_lim  <= (ACC_W'(i_cnt) * ACC_W'(3)) << ROOT_SHIFT;
                r_gain <= '0;
                r_bit  <= BIT_W'(GAIN_W - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (cand <= r_lim) begin
                    r_p           <= cand;
                    r_gain[r_bit] <= 1'b1;
                    r_a           <= (r_a >> 1) + r_b;
                end else begin
                    r_a <= r_a >> 1;
                end
                r_b   <= r_b >> 2;
                r_bit <= r_bit - BIT_W'(1);
                if (r_bit == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_gain = r_gain;

endmodule

// ===== hdl/three_component_agc_unit.sv =====
// ----------------------------------------------------------------------------
// three_component_agc_unit
// sliding-window rms gain control over three-component samples
// ----------------------------------------------------------------------------
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata {z,y,x}, tlast end of trace
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata {gain,z,y,x}, tlast end of trace
//  cfg       in   i_cfg_we                      i_cfg_wdata half window
//
//  one item at a time: a sample is taken in, stored and squared; each result runs
//  the 32-step gain search, skipped when the energy is zero; a window eviction
//  reads and subtracts the oldest sample; a trace end adds up to W more results
//  reset is synchronous; the sample store needs no clearing pass
//  a stalled output holds the sequencer in its output state
// ----------------------------------------------------------------------------
module three_component_agc_unit
    import tca_pkg::*;
#(
    parameter int MAX_HALF_WINDOW = 32,
    parameter int SAMPLE_BITS     = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // comp_x, comp_y, comp_z, zero pad
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                     s_axis_tlast,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // out_x, out_y, out_z, gain_value, zero pad
    output logic [((3*SAMPLE_BITS+GAIN_W+7)/8)*8-1:0] m_axis_tdata,
    output logic                     m_axis_tlast,
    input  logic                     i_cfg_we,
    input  logic [CFG_W-1:0]         i_cfg_wdata
);

    localparam int DEPTH  = 2 * MAX_HALF_WINDOW + 1;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SEL_W  = $clog2(2 * DEPTH + 1);
    localparam int HW_W   = $clog2(MAX_HALF_WINDOW + 1);
    localparam int SB     = SAMPLE_BITS;
    localparam int SSQ_W  = 2 * SB - 2 + $clog2(3 * DEPTH + 1);
    localparam int OUT_W  = ((3 * SB + GAIN_W + 7) / 8) * 8;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_ADD, S_REM_RD, S_REM_SQ, S_REM_SUB,
        S_EM_CHK, S_GAIN, S_RD, S_SCALE, S_OUT, S_NEXT
    } t_state;

    t_state               r_state;
    logic [CFG_W-1:0]     r_half_window;
    logic [HW_W-1:0]      r_w;
    logic [HW_W-1:0]      w_clamped;
    logic [SSQ_W-1:0]     r_ssq;
    logic [CNT_W-1:0]     r_count;
    logic [PTR_W-1:0]     r_wp;
    logic [CNT_W-1:0]     r_seen;
    logic [GAIN_W-1:0]    r_held;
    logic [GAIN_W-1:0]    r_gain;
    logic [HW_W-1:0]      r_ahead;
    logic [HW_W-1:0]      r_pend;
    logic                 r_elast;
    logic                 r_rem_to_write;
    logic signed [SB-1:0] r_in_x, r_in_y, r_in_z;
    logic                 r_in_last;
    logic                 r_m_valid;
    logic [OUT_W-1:0]     r_m_data;
    logic                 r_m_last;

    logic [3*SB-1:0]      mem [DEPTH];
    logic [3*SB-1:0]      r_rdata;
    logic [PTR_W-1:0]     rd_addr;
    logic                 mem_we;

    logic signed [SB-1:0] lane_in_x, lane_in_y, lane_in_z;
    logic [2*SB-1:0]      sq_x, sq_y, sq_z;
    logic signed [SB-1:0] sc_x, sc_y, sc_z;
    logic [SSQ_W-1:0]     sq_sum;
    logic [CNT_W-1:0]     seen_inc;
    logic                 need_evict;
    logic                 rs_start;
    logic                 rs_done;
    logic [GAIN_W-1:0]    rs_gain;

    function automatic logic [PTR_W-1:0] slot_back(input logic [PTR_W-1:0] wp,
                                                   input logic [CNT_W-1:0] k);
        logic [SEL_W-1:0] km;
        logic [SEL_W-1:0] t;
        km = (k >= CNT_W'(DEPTH)) ? '0 : SEL_W'(k);
        t  = SEL_W'(wp) + SEL_W'(DEPTH) - km;
        if (t >= SEL_W'(DEPTH)) begin
            t = t - SEL_W'(DEPTH);
        end
        return PTR_W'(t);
    endfunction

    always_comb begin
        if (r_half_window == '0) begin
            w_clamped = HW_W'(1);
        end else if (r_half_window > CFG_W'(MAX_HALF_WINDOW)) begin
            w_clamped = HW_W'(MAX_HALF_WINDOW);
        end else begin
            w_clamped = HW_W'(r_half_window);
        end
    end

    // ---- sample store
    assign mem_we = (r_state == S_SQ);

    always_comb begin
        if (r_state == S_REM_RD) begin
            rd_addr = slot_back(r_wp, r_count);
        end else begin
            rd_addr = slot_back(r_wp, CNT_W'(r_ahead) + CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_wp] <= {r_in_z, r_in_y, r_in_x};
        end
        r_rdata <= mem[rd_addr];
    end

    // ---- component lanes
    assign lane_in_x = (r_state == S_SQ) ? r_in_x : $signed(r_rdata[SB-1:0]);
    assign lane_in_y = (r_state == S_SQ) ? r_in_y : $signed(r_rdata[2*SB-1:SB]);
    assign lane_in_z = (r_state == S_SQ) ? r_in_z : $signed(r_rdata[3*SB-1:2*SB]);

    tca_lane #(.SAMPLE_BITS(SB)) u_lane_x (
        .i_clk(i_clk), .i_sample(lane_in_x), .i_gain(r_gain),
        .o_square(sq_x), .o_scaled(sc_x)
    );
    tca_lane #(.SAMPLE_BITS(SB)) u_lane_y (
        .i_clk(i_clk), .i_sample(lane_in_y), .i_gain(r_gain),
        .o_square(sq_y), .o_scaled(sc_y)
    );
    tca_lane #(.SAMPLE_BITS(SB)) u_lane_z (
        .i_clk(i_clk), .i_sample(lane_in_z), .i_gain(r_gain),
        .o_square(sq_z), .o_scaled(sc_z)
    );

    // merge of the three lane energies
    assign sq_sum = SSQ_W'(sq_x) + SSQ_W'(sq_y) + SSQ_W'(sq_z);

    // ---- gain search
    assign need_evict = (r_count > CNT_W'(r_ahead) + CNT_W'(r_w) + CNT_W'(1));
    assign rs_start   = (r_state == S_EM_CHK) && !need_evict && (r_ssq != '0);

    tca_rsqrt #(.SSQ_W(SSQ_W), .CNT_W(CNT_W)) u_rsqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(rs_start),
        .i_ssq(r_ssq), .i_cnt(r_count), .o_done(rs_done), .o_gain(rs_gain)
    );

    assign seen_inc = (r_seen < CNT_W'(DEPTH)) ? r_seen + CNT_W'(1) : r_seen;

    // ---- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_half_window  <= HALF_WINDOW_RESET;
            r_w            <= HW_W'(HALF_WINDOW_RESET);
            r_ssq          <= '0;
            r_count        <= '0;
            r_wp           <= '0;
            r_seen         <= '0;
            r_held         <= '0;
            r_m_valid      <= 1'b0;
            r_rem_to_write <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_half_window <= i_cfg_wdata;
            end
            // the output state loads the register itself
            if (r_m_valid && m_axis_tready && r_state != S_OUT) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_in_x    <= $signed(s_axis_tdata[SB-1:0]);
                        r_in_y    <= $signed(s_axis_tdata[2*SB-1:SB]);
                        r_in_z    <= $signed(s_axis_tdata[3*SB-1:2*SB]);
                        r_in_last <= s_axis_tlast;
                        if (r_seen == '0) begin
                            r_w <= w_clamped;
                        end
                        if (r_count >= CNT_W'(DEPTH)) begin
                            r_rem_to_write <= 1'b1;
                            r_state        <= S_REM_RD;
                        end else begin
                            r_state <= S_SQ;
                        end
                    end
                end
                S_SQ: r_state <= S_ADD;
                S_ADD: begin
                    r_ssq   <= r_ssq + sq_sum;
                    r_wp    <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
                    r_count <= r_count + CNT_W'(1);
                    r_seen  <= seen_inc;
                    if (seen_inc > CNT_W'(r_w)) begin
                        r_ahead <= r_w;
                        r_pend  <= r_w;
                        r_elast <= 1'b0;
                        r_state <= S_EM_CHK;
                    end else begin
                        r_pend  <= HW_W'(seen_inc);
                        r_state <= S_NEXT;
                    end
                end
                S_REM_RD:  r_state <= S_REM_SQ;
                S_REM_SQ:  r_state <= S_REM_SUB;
                S_REM_SUB: begin
                    r_ssq          <= r_ssq - sq_sum;
                    r_count        <= r_count - CNT_W'(1);
                    r_rem_to_write <= 1'b0;
                    r_state        <= r_rem_to_write ? S_SQ : S_EM_CHK;
                end
                S_EM_CHK: begin
                    if (need_evict) begin
                        r_state <= S_REM_RD;
                    end else if (r_ssq == '0) begin
                        r_gain  <= r_held;
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_GAIN;
                    end
                end
                S_GAIN: begin
                    if (rs_done) begin
                        r_gain  <= rs_gain;
                        r_held  <= rs_gain;
                        r_state <= S_RD;
                    end
                end
                S_RD:    r_state <= S_SCALE;
                S_SCALE: r_state <= S_OUT;
                S_OUT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= OUT_W'({r_gain, sc_z, sc_y, sc_x});
                        r_m_last  <= r_elast;
                        r_state   <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_in_last && r_pend != '0) begin
                        r_ahead <= r_pend - HW_W'(1);
                        r_pend  <= r_pend - HW_W'(1);
                        r_elast <= (r_pend == HW_W'(1));
                        r_state <= S_EM_CHK;
                    end else begin
                        // end of trace clears the running window
                        if (r_in_last) begin
                            r_ssq   <= '0;
                            r_count <= '0;
                            r_wp    <= '0;
                            r_seen  <= '0;
                            r_held  <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = i_rst_n && (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

endmodule

// ===== hdl/tca_checker.sv =====
// ----------------------------------------------------------------------------
// tca_checker
// port-level checks of the gain control block
// ----------------------------------------------------------------------------
module tca_checker
    import tca_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     s_axis_tvalid,
    input logic                     s_axis_tready,
    input logic                     m_axis_tvalid,
    input logic                     m_axis_tready,
    input logic [((3*SAMPLE_BITS+GAIN_W+7)/8)*8-1:0] m_axis_tdata,
    input logic                     m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("output transfer changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_zero_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3*SAMPLE_BITS+GAIN_W-1:3*SAMPLE_BITS] == '0
            |-> m_axis_tdata[3*SAMPLE_BITS-1:0] == '0)
        else $error("nonzero sample with zero gain");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

endmodule

bind three_component_agc_unit tca_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_tca_checker (.*);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the three-component sliding-window gain control:
// traces are streamed in at several half-window settings with random gaps and
// back-pressure, and every output transfer is compared with a local predictor
// ----------------------------------------------------------------------------
module testbench;
    import tca_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_HW     = 32;
    localparam int SBITS      = 24;
    localparam int DEPTH      = 2 * MAX_HW + 1;
    localparam int IN_W       = ((3 * SBITS + 7) / 8) * 8;
    localparam int OUT_W      = ((3 * SBITS + GAIN_W + 7) / 8) * 8;
    localparam int DOG_LIMIT  = 20000;
    localparam int HOLD_LEN   = 600;
    localparam int SETTLE     = 200;
    localparam logic signed [SBITS-1:0] S_MAX = {1'b0, {(SBITS-1){1'b1}}};
    localparam logic signed [SBITS-1:0] S_MIN = {1'b1, {(SBITS-1){1'b0}}};

    typedef struct {
        logic signed [SBITS-1:0] x, y, z;
        logic                    last;
    } t_sample;

    typedef struct {
        logic [SBITS-1:0]  x, y, z;
        logic [GAIN_W-1:0] gain;
        logic              last;
    } t_gained;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;   // comp_x, comp_y, comp_z, zero pad
    logic              s_axis_tlast;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;   // out_x, out_y, out_z, gain_value
    logic              m_axis_tlast;
    logic              i_cfg_we;
    logic [CFG_W-1:0]  i_cfg_wdata;

    three_component_agc_unit #(.MAX_HALF_WINDOW(MAX_HW), .SAMPLE_BITS(SBITS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    t_sample pending_q[$];
    t_gained gained_q[$];
    int      mismatches = 0;
    bit      calm = 0;
    bit      hold_req = 0;
    bit      hold_done = 0;
    int      hold_left = 0;
    int      quiet_cycles = 0;

    // predictor state
    logic signed [SBITS-1:0] win_x[DEPTH], win_y[DEPTH], win_z[DEPTH];
    longint unsigned         energy;
    int                      win_cnt, wr_ptr, seen, act_w;
    logic [GAIN_W-1:0]       last_gain;
    logic [CFG_W-1:0]        hw_reg;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint unsigned sq(logic signed [SBITS-1:0] v);
        longint s;
        s = v;
        return s * s;
    endfunction

    function automatic int slot_back(int k);
        return (wr_ptr + DEPTH - (k % DEPTH)) % DEPTH;
    endfunction

    function automatic logic [GAIN_W-1:0] rms_gain(longint unsigned ssq, int cnt);
        logic [127:0]      bound, cc, prod;
        logic [GAIN_W-1:0] g, c;
        bound = 128'(3 * cnt) << ROOT_SHIFT;
        g = '0;
        for (int b = GAIN_W - 1; b >= 0; b--) begin
            c = g | (32'd1 << b);
            cc = c;
            prod = cc * cc * 128'(ssq);
            if (prod <= bound)
                g = c;
        end
        return g;
    endfunction

    function automatic logic [SBITS-1:0] apply_gain(logic [GAIN_W-1:0] g,
                                                    logic signed [SBITS-1:0] v);
        longint          sv;
        longint unsigned mag, q;
        sv = v;
        mag = (sv < 0 ? -sv : sv) * longint'(g);
        if (sv < 0) begin
            q = (mag + (64'd1 << OUT_SHIFT) - 1) >> OUT_SHIFT;
            return (q > 64'd8388608) ? S_MIN : SBITS'(-longint'(q));
        end
        q = mag >> OUT_SHIFT;
        return (q > 64'd8388607) ? S_MAX : SBITS'(q);
    endfunction

    task automatic drop_oldest();
        int idx;
        if (win_cnt == 0)
            return;
        idx = slot_back(win_cnt);
        energy -= sq(win_x[idx]) + sq(win_y[idx]) + sq(win_z[idx]);
        win_cnt--;
    endtask

    task automatic predict_output(int ahead, bit last);
        int      lag, idx;
        t_gained r;
        lag = win_cnt - 1 - ahead;
        while (lag > act_w) begin
            drop_oldest();
            lag--;
        end
        if (energy != 0)
            last_gain = rms_gain(energy, win_cnt);
        idx = slot_back(ahead + 1);
        r.x = apply_gain(last_gain, win_x[idx]);
        r.y = apply_gain(last_gain, win_y[idx]);
        r.z = apply_gain(last_gain, win_z[idx]);
        r.gain = last_gain;
        r.last = last;
        gained_q = {gained_q, r};
    endtask

    task automatic track_sample(t_sample s);
        int left;
        if (seen == 0)
            act_w = (hw_reg == 0) ? 1 : (hw_reg > MAX_HW) ? MAX_HW : int'(hw_reg);
        if (win_cnt >= DEPTH)
            drop_oldest();
        win_x[wr_ptr] = s.x;
        win_y[wr_ptr] = s.y;
        win_z[wr_ptr] = s.z;
        energy += sq(s.x) + sq(s.y) + sq(s.z);
        wr_ptr = (wr_ptr + 1) % DEPTH;
        win_cnt++;
        if (seen < DEPTH)
            seen++;
        if (seen > act_w) begin
            predict_output(act_w, 0);
            left = act_w;
        end else begin
            left = seen;
        end
        if (s.last) begin
            while (left > 0) begin
                left--;
                predict_output(left, left == 0);
            end
            energy = 0;
            win_cnt = 0;
            wr_ptr = 0;
            seen = 0;
            last_gain = '0;
        end
    endtask

    // input side: predictor follows every accepted transfer and register write
    always @(posedge i_clk) begin
        t_sample s;
        if (!i_rst_n) begin
            energy = 0;
            win_cnt = 0;
            wr_ptr = 0;
            seen = 0;
            last_gain = '0;
            act_w = 8;
            hw_reg = HALF_WINDOW_RESET;
        end else begin
            if (i_cfg_we)
                hw_reg = i_cfg_wdata;
            if (s_axis_tvalid && s_axis_tready) begin
                s.x = s_axis_tdata[SBITS-1:0];
                s.y = s_axis_tdata[2*SBITS-1:SBITS];
                s.z = s_axis_tdata[3*SBITS-1:2*SBITS];
                s.last = s_axis_tlast;
                track_sample(s);
            end
        end
    end

    // driver
    always @(posedge i_clk) begin
        t_sample s;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
                s = pending_q.pop_front();
                s_axis_tdata <= {{(IN_W-3*SBITS){1'b0}}, s.z, s.y, s.x};
                s_axis_tlast <= s.last;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, started once at the first offered output after the request
    always @(posedge i_clk) begin
        if (hold_req && !hold_done && m_axis_tvalid) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_gained want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= (hold_left == 0) && (calm || $urandom_range(99) >= 33);
            if (m_axis_tvalid && m_axis_tready) begin
                if (gained_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output transfer: tdata %h tlast %b",
                                 m_axis_tdata, m_axis_tlast);
                end else begin
                    want = gained_q.pop_front();
                    if (m_axis_tdata[SBITS-1:0] !== want.x
                        || m_axis_tdata[2*SBITS-1:SBITS] !== want.y
                        || m_axis_tdata[3*SBITS-1:2*SBITS] !== want.z
                        || m_axis_tdata[3*SBITS+GAIN_W-1:3*SBITS] !== want.gain
                        || m_axis_tlast !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("output mismatch: exp x %h y %h z %h gain %h last %b,",
                                     want.x, want.y, want.z, want.gain, want.last,
                                     " got x %h y %h z %h gain %h last %b",
                                     m_axis_tdata[SBITS-1:0],
                                     m_axis_tdata[2*SBITS-1:SBITS],
                                     m_axis_tdata[3*SBITS-1:2*SBITS],
                                     m_axis_tdata[3*SBITS+GAIN_W-1:3*SBITS],
                                     m_axis_tlast);
                    end
                end
            end
        end
    end

    // watchdog: cycles of outstanding work with no transfer on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (pending_q.size() == 0 && !s_axis_tvalid && gained_q.size() == 0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= DOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic signed [SBITS-1:0] pick_comp();
        case ($urandom_range(9))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return SBITS'($urandom_range(15)) - 8;
            3:       return SBITS'($urandom_range(2047)) - 1024;
            default: return SBITS'($urandom);
        endcase
    endfunction

    task automatic add_sample(logic signed [SBITS-1:0] x, y, z, bit last);
        t_sample s;
        s.x = x;
        s.y = y;
        s.z = z;
        s.last = last;
        pending_q = {pending_q, s};
    endtask

    // random trace; some end in a run of zeros so the gain has to be held
    task automatic add_trace(int len);
        int zero_from;
        zero_from = ($urandom_range(3) == 0) ? $urandom_range(len) : len;
        for (int i = 0; i < len; i++) begin
            if (i >= zero_from)
                add_sample('0, '0, '0, i == len - 1);
            else
                add_sample(pick_comp(), pick_comp(), pick_comp(), i == len - 1);
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_q.size() != 0 || s_axis_tvalid || gained_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_half_window(logic [CFG_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [CFG_W-1:0] settings[6];
        int               eff, budget;
        settings = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd5, 6'd0};
        settings[5] = CFG_W'($urandom_range(1, 20));
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed traces at the reset half window
        add_sample(S_MAX, S_MAX, S_MAX, 0);
        add_sample(S_MIN, S_MIN, S_MIN, 0);
        add_sample(S_MAX, S_MIN, 0, 0);
        add_sample(1, -1, 0, 0);
        add_sample(0, 0, 0, 0);
        add_sample(-1, -1, -1, 0);
        add_sample(S_MIN, 1, S_MAX, 0);
        add_sample(2, 0, 0, 0);
        add_sample(0, 0, 3, 0);
        add_sample(S_MAX, 0, 0, 0);
        add_sample(0, 0, 0, 1);
        // short trace and all-zero traces
        add_sample(100, -200, 300, 0);
        add_sample(-5, 7, 0, 0);
        add_sample(S_MIN, S_MIN, S_MIN, 1);
        add_sample(0, 0, 0, 1);
        add_sample(0, 0, 0, 0);
        add_sample(0, 0, 0, 1);
        add_sample(S_MAX, -1, 1, 1);
        wait_idle();

        foreach (settings[p]) begin
            write_half_window(settings[p]);
            eff = (settings[p] == 0) ? 1 : (settings[p] > MAX_HW) ? MAX_HW : settings[p];
            calm = (p == 4);
            if (p == 1)
                hold_req = 1'b1;
            budget = 18;
            // a trace longer than the window makes the flush emit the most results
            if (settings[p] == CFG_W'(MAX_HW)) begin
                add_trace(2 * MAX_HW + 6);
                budget = 0;
            end
            while (budget > 0) begin
                eff = $urandom_range(1, 3 * eff + 4);
                if (eff > budget)
                    eff = budget;
                add_trace(eff);
                budget -= eff;
                eff = (settings[p] == 0) ? 1 : (settings[p] > MAX_HW) ? MAX_HW
                                                                      : settings[p];
            end
            wait_idle();
        end
        calm = 0;

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== three_component_agc_unit.f =====
hdl/tca_pkg.sv
hdl/tca_lane.sv
hdl/tca_rsqrt.sv
hdl/three_component_agc_unit.sv
hdl/tca_checker.sv
verif/testbench.sv
